/* rtl/rvtc_pkg.sv */
// ----------------------------------------------------------------------------
// Rank-vote template classifier package
// Shared constants, row layout, status codes and feature helpers.
// ----------------------------------------------------------------------------
package rvtc_pkg;

  localparam int unsigned MAX_TEMPLATES = 64;
  localparam int unsigned NUM_FEATURES  = 8;
  localparam int unsigned HOLLOW_FEAT   = 4;
  localparam int unsigned FEAT_W        = 24;

  localparam int unsigned IDX_W   = (MAX_TEMPLATES > 1) ? $clog2(MAX_TEMPLATES) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_TEMPLATES + 1);
  localparam int unsigned SCORE_W = $clog2(8 * MAX_TEMPLATES + 1);
  localparam int unsigned AHEAD_W = $clog2(NUM_FEATURES + 1);

  localparam int unsigned OUT_IDX_W   = 6;
  localparam int unsigned OUT_SCORE_W = 10;

  typedef enum logic [2:0] {
    ST_ADDED      = 3'd0,
    ST_TAG_EXISTS = 3'd1,
    ST_SIMILAR    = 3'd2,
    ST_FULL       = 3'd3,
    ST_CLASSIFIED = 3'd4,
    ST_EMPTY      = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0]  tag;
    logic [23:0] area;
    logic [23:0] perimeter;
    logic [15:0] major_len;
    logic [15:0] minor_len;
    logic        hollow;
    logic [17:0] rectangularity;
    logic [17:0] solidity;
    logic [17:0] eccentricity;
  } row_t;

  localparam int unsigned ROW_W = $bits(row_t);

  typedef logic [NUM_FEATURES-1:0][FEAT_W-1:0] feat_vec_t;

  typedef struct packed {
    feat_vec_t          diff;
    logic [AHEAD_W-1:0] ahead;
    logic               similar;
  } cmp_res_t;

  function automatic feat_vec_t row_features(row_t r);
    feat_vec_t v;
    v[0] = r.area;
    v[1] = r.perimeter;
    v[2] = {8'd0, r.major_len};
    v[3] = {8'd0, r.minor_len};
    v[4] = {23'd0, r.hollow};
    v[5] = {6'd0, r.rectangularity};
    v[6] = {6'd0, r.solidity};
    v[7] = {6'd0, r.eccentricity};
    return v;
  endfunction

endpackage

/* rtl/rvtc_in_if.sv */
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one add or classify item.
// ----------------------------------------------------------------------------
interface rvtc_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  class_tag;
  logic [23:0] area;
  logic [23:0] perimeter;
  logic [15:0] major_len;
  logic [15:0] minor_len;
  logic        hollow;
  logic [17:0] rectangularity;
  logic [17:0] solidity;
  logic [17:0] eccentricity;

  modport source (
    output valid, kind, class_tag, area, perimeter, major_len, minor_len, hollow,
           rectangularity, solidity, eccentricity,
    input  ready
  );
  modport sink (
    input  valid, kind, class_tag, area, perimeter, major_len, minor_len, hollow,
           rectangularity, solidity, eccentricity,
    output ready
  );
endinterface

/* rtl/rvtc_out_if.sv */
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel carrying one result per input item.
// ----------------------------------------------------------------------------
interface rvtc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] best_tag;
  logic [5:0] best_index;
  logic [9:0] best_score;

  modport source (output valid, status, best_tag, best_index, best_score, input ready);
  modport sink   (input valid, status, best_tag, best_index, best_score, output ready);
endinterface

/* rtl/rvtc_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rvtc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/rvtc_cmp.sv */
// ----------------------------------------------------------------------------
// Feature compare unit
// Eight lanes of difference, rank and similarity compare for one row.
// ----------------------------------------------------------------------------
module rvtc_cmp (
  input  rvtc_pkg::feat_vec_t query_i,
  input  rvtc_pkg::feat_vec_t stored_i,
  input  rvtc_pkg::feat_vec_t ref_diff_i,
  input  logic                lower_idx_i,
  output rvtc_pkg::cmp_res_t  res_o
);
  import rvtc_pkg::*;

  logic [FEAT_W-1:0]   d;
  logic [FEAT_W+3:0]   ten_d;
  logic signed [5:0]   flag;
  logic [AHEAD_W-1:0]  cnt;

  always_comb begin
    res_o.diff = '0;
    cnt  = '0;
    flag = '0;
    d     = '0;
    ten_d = '0;
    for (int f = 0; f < NUM_FEATURES; f++) begin
      d = (stored_i[f] > query_i[f]) ? stored_i[f] - query_i[f] : query_i[f] - stored_i[f];
      res_o.diff[f] = d;
      // A row ranks ahead when it is closer, or equally close with a lower index.
      if (d < ref_diff_i[f] || (d == ref_diff_i[f] && lower_idx_i)) begin
        cnt = cnt + AHEAD_W'(1);
      end
      ten_d = ({4'd0, d} << 3) + ({4'd0, d} << 1);
      if (f == HOLLOW_FEAT) begin
        flag = (stored_i[f] == query_i[f]) ? flag + 6'sd2 : flag - 6'sd2;
      end else begin
        flag = (ten_d < {4'd0, stored_i[f]}) ? flag + 6'sd1 : flag - 6'sd2;
      end
    end
    res_o.ahead   = cnt;
    res_o.similar = (flag > 6'sd0);
  end
endmodule

/* rtl/rank_vote_template_classifier.sv */
// ----------------------------------------------------------------------------
// Rank-vote template classifier
// Template store with similarity-checked adds and rank-count classification.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_i (valid/ready); each gives exactly one result
// transaction on out_o. kind 0 adds a template, kind 1 classifies a query.
// The block takes one item at a time: in_i.ready is high only while idle,
// and a result is held on out_o until the receiver takes it, stalling input.
// An add scans all n stored rows through the single RAM read port. A
// classify loads each row i and then sweeps all n rows through the
// eight-lane compare unit. An empty classify goes straight from idle to
// the result, with no table read.
// Reset empties the table (count to zero); the template RAM is not cleared,
// since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module rank_vote_template_classifier (
  input logic        clk_i,
  input logic        rst_ni,
  rvtc_in_if.sink    in_i,
  rvtc_out_if.source out_o
);
  import rvtc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_ADD     = 7'b0000010,
    S_ADD_END = 7'b0000100,
    S_LOAD    = 7'b0001000,
    S_LOADW   = 7'b0010000,
    S_SCAN    = 7'b0100000,
    S_OUT     = 7'b1000000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   n_q, n_d;
  logic [CNT_W-1:0]   i_q, i_d;
  logic [CNT_W-1:0]   rj_q, rj_d;
  logic [CNT_W-1:0]   j1_q, j1_d;
  logic               v1_q, v1_d;
  logic [SCORE_W-1:0] acc_q, acc_d;
  logic [SCORE_W-1:0] best_score_q, best_score_d;
  logic [IDX_W-1:0]   best_idx_q, best_idx_d;
  logic [7:0]         best_tag_q, best_tag_d;
  logic [7:0]         itag_q, itag_d;
  logic               any_tag_q, any_tag_d;
  logic               any_sim_q, any_sim_d;
  status_e            status_q, status_d;
  row_t               qrow_q, qrow_d;
  feat_vec_t          di_q, di_d;

  logic [ROW_W-1:0]   rdata;
  row_t               rrow;
  logic [IDX_W-1:0]   raddr;
  logic               we;
  logic [SCORE_W-1:0] score;
  logic               issue;
  cmp_res_t           res;

  assign rrow  = row_t'(rdata);
  assign raddr = (state_q == S_LOAD) ? i_q[IDX_W-1:0] : rj_q[IDX_W-1:0];
  assign we    = (state_q == S_ADD_END) && !any_tag_q && !any_sim_q &&
                 (n_q != CNT_W'(MAX_TEMPLATES));
  assign issue = (rj_q < n_q);
  assign score = SCORE_W'({n_q, 3'b000}) - acc_q;

  rvtc_ram #(.Width(ROW_W), .Depth(MAX_TEMPLATES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (n_q[IDX_W-1:0]),
    .wdata_i (qrow_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  rvtc_cmp u_cmp (
    .query_i     (row_features(qrow_q)),
    .stored_i    (row_features(rrow)),
    .ref_diff_i  (di_q),
    .lower_idx_i (j1_q < i_q),
    .res_o       (res)
  );

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = (state_q == S_OUT);
  assign out_o.status     = status_q;
  assign out_o.best_tag   = best_tag_q;
  assign out_o.best_index = OUT_IDX_W'(best_idx_q);
  assign out_o.best_score = OUT_SCORE_W'(best_score_q);

  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    i_d          = i_q;
    rj_d         = rj_q;
    j1_d         = j1_q;
    v1_d         = 1'b0;
    acc_d        = acc_q;
    best_score_d = best_score_q;
    best_idx_d   = best_idx_q;
    best_tag_d   = best_tag_q;
    itag_d       = itag_q;
    any_tag_d    = any_tag_q;
    any_sim_d    = any_sim_q;
    status_d     = status_q;
    qrow_d       = qrow_q;
    di_d         = di_q;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          qrow_d = '{tag: in_i.class_tag, area: in_i.area, perimeter: in_i.perimeter,
                     major_len: in_i.major_len, minor_len: in_i.minor_len,
                     hollow: in_i.hollow, rectangularity: in_i.rectangularity,
                     solidity: in_i.solidity, eccentricity: in_i.eccentricity};
          rj_d         = '0;
          i_d          = '0;
          any_tag_d    = 1'b0;
          any_sim_d    = 1'b0;
          best_tag_d   = '0;
          best_idx_d   = '0;
          best_score_d = '0;
          if (!in_i.kind) begin
            state_d = S_ADD;
          end else if (n_q == '0) begin
            status_d = ST_EMPTY;
            state_d  = S_OUT;
          end else begin
            state_d = S_LOAD;
          end
        end
      end
      S_ADD: begin
        // Reads are issued back to back; data for row j1 is valid in the cycle after its read.
        if (issue) begin
          rj_d = rj_q + CNT_W'(1);
          v1_d = 1'b1;
          j1_d = rj_q;
        end
        if (v1_q) begin
          any_tag_d = any_tag_q | (rrow.tag == qrow_q.tag);
          any_sim_d = any_sim_q | res.similar;
        end
        if (!issue && !v1_q) begin
          state_d = S_ADD_END;
        end
      end
      S_ADD_END: begin
        if (any_tag_q) begin
          status_d = ST_TAG_EXISTS;
        end else if (any_sim_q) begin
          status_d = ST_SIMILAR;
        end else if (n_q == CNT_W'(MAX_TEMPLATES)) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_ADDED;
          n_d      = n_q + CNT_W'(1);
        end
        state_d = S_OUT;
      end
      S_LOAD: begin
        state_d = S_LOADW;
      end
      S_LOADW: begin
        di_d    = res.diff;
        itag_d  = rrow.tag;
        rj_d    = '0;
        acc_d   = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (issue) begin
          rj_d = rj_q + CNT_W'(1);
          v1_d = 1'b1;
          j1_d = rj_q;
        end
        if (v1_q) begin
          acc_d = acc_q + SCORE_W'(res.ahead);
        end
        if (!issue && !v1_q) begin
          if (i_q == '0 || score > best_score_q) begin
            best_score_d = score;
            best_idx_d   = i_q[IDX_W-1:0];
            best_tag_d   = itag_q;
          end
          i_d = i_q + CNT_W'(1);
          if (i_q + CNT_W'(1) == n_q) begin
            status_d = ST_CLASSIFIED;
            state_d  = S_OUT;
          end else begin
            state_d = S_LOAD;
          end
        end
      end
      S_OUT: begin
        if (out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      n_q       <= '0;
      v1_q      <= 1'b0;
      status_q  <= ST_ADDED;
      any_tag_q <= 1'b0;
      any_sim_q <= 1'b0;
      i_q       <= '0;
      rj_q      <= '0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      v1_q      <= v1_d;
      status_q  <= status_d;
      any_tag_q <= any_tag_d;
      any_sim_q <= any_sim_d;
      i_q       <= i_d;
      rj_q      <= rj_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j1_q         <= j1_d;
    acc_q        <= acc_d;
    best_score_q <= best_score_d;
    best_idx_q   <= best_idx_d;
    best_tag_q   <= best_tag_d;
    itag_q       <= itag_d;
    qrow_q       <= qrow_d;
    di_q         <= di_d;
  end
endmodule

/* rtl/rvtc_chk.sv */
// ----------------------------------------------------------------------------
// Rank-vote template classifier checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module rvtc_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] status_i,
  input logic [9:0] best_score_i
);
  import rvtc_pkg::*;

  // A waiting result holds its status.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(status_i))
    else $error("result changed while stalled");

  // One item at a time: no new item while a result is outstanding.
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while result pending");

  // An accepted transaction leaves the block busy in the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after acceptance");

  // Only classified results carry a score.
  a_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_CLASSIFIED) |-> best_score_i == '0)
    else $error("score on non-classify result");
endmodule

bind rank_vote_template_classifier rvtc_chk u_rvtc_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .status_i     (out_o.status),
  .best_score_i (out_o.best_score)
);

/* sim/rvtc_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rank-vote classifier result checker
// Watches both channels, keeps its own template table and predicts the
// result of every accepted item, then compares each result field by field.
// ----------------------------------------------------------------------------
module rvtc_checker
  import rvtc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  rvtc_in_if   in_i,
  rvtc_out_if  out_i,
  output int   fail_count_o,
  output int   checked_o,
  output int   pending_o,
  output int   table_count_o
);

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] best_tag;
    logic [5:0] best_index;
    logic [9:0] best_score;
  } verdict_t;

  typedef longint unsigned feat_arr_t [NUM_FEATURES];

  row_t     table_rows [MAX_TEMPLATES];
  int       table_count;
  verdict_t verdict_q [$];
  int       fail_count;
  int       checked;

  assign fail_count_o  = fail_count;
  assign checked_o     = checked;
  assign pending_o     = verdict_q.size();
  assign table_count_o = table_count;

  function automatic feat_arr_t unpack_feats(row_t r);
    feat_arr_t v;
    v[0] = r.area;
    v[1] = r.perimeter;
    v[2] = r.major_len;
    v[3] = r.minor_len;
    v[4] = r.hollow;
    v[5] = r.rectangularity;
    v[6] = r.solidity;
    v[7] = r.eccentricity;
    return v;
  endfunction

  function automatic longint unsigned gap(longint unsigned a, longint unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic bit near_copy(row_t q, row_t s);
    feat_arr_t qf;
    feat_arr_t sf;
    int        flag;
    qf   = unpack_feats(q);
    sf   = unpack_feats(s);
    flag = 0;
    for (int f = 0; f < NUM_FEATURES; f++) begin
      if (f == HOLLOW_FEAT) flag += (qf[f] == sf[f]) ? 2 : -2;
      else flag += (10 * gap(qf[f], sf[f]) < sf[f]) ? 1 : -2;
    end
    return flag > 0;
  endfunction

  // Applies one item to the table and returns the result it should give.
  function automatic verdict_t apply_item(logic kind, row_t q);
    verdict_t  v;
    feat_arr_t qf;
    feat_arr_t feats [MAX_TEMPLATES];
    int        score [MAX_TEMPLATES];
    int        ahead;
    int        best;
    v  = '0;
    qf = unpack_feats(q);
    if (kind == 1'b0) begin
      for (int i = 0; i < table_count; i++)
        if (table_rows[i].tag == q.tag) begin
          v.status = ST_TAG_EXISTS;
          return v;
        end
      for (int i = 0; i < table_count; i++)
        if (near_copy(q, table_rows[i])) begin
          v.status = ST_SIMILAR;
          return v;
        end
      if (table_count >= MAX_TEMPLATES) begin
        v.status = ST_FULL;
        return v;
      end
      table_rows[table_count] = q;
      table_count++;
      v.status = ST_ADDED;
      return v;
    end
    if (table_count == 0) begin
      v.status = ST_EMPTY;
      return v;
    end
    for (int i = 0; i < table_count; i++) begin
      feats[i] = unpack_feats(table_rows[i]);
      score[i] = 0;
    end
    for (int f = 0; f < NUM_FEATURES; f++)
      for (int i = 0; i < table_count; i++) begin
        ahead = 0;
        for (int j = 0; j < table_count; j++)
          if (gap(feats[j][f], qf[f]) < gap(feats[i][f], qf[f]) ||
              (gap(feats[j][f], qf[f]) == gap(feats[i][f], qf[f]) && j < i))
            ahead++;
        score[i] += table_count - ahead;
      end
    best = 0;
    for (int i = 1; i < table_count; i++)
      if (score[i] > score[best]) best = i;
    v.status     = ST_CLASSIFIED;
    v.best_tag   = table_rows[best].tag;
    v.best_index = best[5:0];
    v.best_score = score[best][9:0];
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    row_t     q;
    verdict_t want;
    verdict_t got;
    if (!rst_ni) begin
      table_count = 0;
      fail_count  <= 0;
      checked     <= 0;
      verdict_q.delete();
    end else begin
      if (in_i.valid && in_i.ready) begin
        q = '{tag: in_i.class_tag, area: in_i.area, perimeter: in_i.perimeter,
              major_len: in_i.major_len, minor_len: in_i.minor_len,
              hollow: in_i.hollow, rectangularity: in_i.rectangularity,
              solidity: in_i.solidity, eccentricity: in_i.eccentricity};
        verdict_q.push_back(apply_item(in_i.kind, q));
      end
      if (out_i.valid && out_i.ready) begin
        got = '{out_i.status, out_i.best_tag, out_i.best_index, out_i.best_score};
        checked <= checked + 1;
        if (verdict_q.size() == 0) begin
          if (fail_count < 10)
            $display("ERROR: result transaction with nothing expected: status %0d",
                     got.status);
          fail_count <= fail_count + 1;
        end else begin
          want = verdict_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("ERROR: status %0d/%0d tag %0d/%0d index %0d/%0d score %0d/%0d %s",
                       want.status, got.status, want.best_tag, got.best_tag,
                       want.best_index, got.best_index, want.best_score,
                       got.best_score, "(expected/actual)");
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

/* sim/tb_rank_vote_template_classifier.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rank-vote template classifier testbench
// Drives directed and random add/classify items with varying idle patterns
// on both channels; a checker alongside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_rank_vote_template_classifier;
  import rvtc_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  idle_mode_e idle_mode = IDLE_NONE;
  int         fail_count;
  int         checked;
  int         pending;
  int         table_count;
  int         items_sent = 0;
  int         classify_sent = 0;
  int         quiet_cycles = 0;
  row_t       added_rows [$];

  rvtc_in_if  in_ch ();
  rvtc_out_if out_ch ();

  rank_vote_template_classifier dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  rvtc_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_ch),
    .out_i         (out_ch),
    .fail_count_o  (fail_count),
    .checked_o     (checked),
    .pending_o     (pending),
    .table_count_o (table_count)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    in_ch.valid          = 1'b0;
    in_ch.kind           = 1'b0;
    in_ch.class_tag      = '0;
    in_ch.area           = '0;
    in_ch.perimeter      = '0;
    in_ch.major_len      = '0;
    in_ch.minor_len      = '0;
    in_ch.hollow         = 1'b0;
    in_ch.rectangularity = '0;
    in_ch.solidity       = '0;
    in_ch.eccentricity   = '0;
    out_ch.ready         = 1'b0;
  end

  // The receiver stalls 80 percent of the time in receiver-only idling, 24 percent when both sides idle.
  always @(negedge clk_i) begin
    if (idle_mode == IDLE_RECEIVER) out_ch.ready <= ($urandom_range(99) >= 80);
    else if (idle_mode == IDLE_BOTH) out_ch.ready <= ($urandom_range(99) >= 24);
    else out_ch.ready <= 1'b1;
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [23:0] pick_value(int w);
    logic [23:0] full;
    int          r;
    full = 24'((longint'(1) << w) - 1);
    r    = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return full;
    return 24'($urandom) & full;
  endfunction

  function automatic row_t fresh_row();
    row_t r;
    r.tag            = 8'($urandom);
    r.area           = pick_value(24);
    r.perimeter      = pick_value(24);
    r.major_len      = 16'(pick_value(16));
    r.minor_len      = 16'(pick_value(16));
    r.hollow         = 1'($urandom);
    r.rectangularity = 18'(pick_value(18));
    r.solidity       = 18'(pick_value(18));
    r.eccentricity   = 18'(pick_value(18));
    return r;
  endfunction

  // Moves a value by at most a twentieth of itself, keeping it in range.
  function automatic logic [23:0] nudge(logic [23:0] s, int w);
    logic [23:0] d;
    logic [23:0] full;
    full = 24'((longint'(1) << w) - 1);
    d    = (s / 20 == 0) ? 24'd0 : 24'($urandom_range(s / 20));
    if ($urandom_range(1) && s <= full - d) return s + d;
    return (s >= d) ? s - d : s;
  endfunction

  function automatic row_t near_row(row_t s);
    row_t r;
    r                = s;
    r.tag            = 8'($urandom);
    r.area           = nudge(s.area, 24);
    r.perimeter      = nudge(s.perimeter, 24);
    r.major_len      = 16'(nudge(24'(s.major_len), 16));
    r.minor_len      = 16'(nudge(24'(s.minor_len), 16));
    r.rectangularity = 18'(nudge(24'(s.rectangularity), 18));
    r.solidity       = 18'(nudge(24'(s.solidity), 18));
    r.eccentricity   = 18'(nudge(24'(s.eccentricity), 18));
    return r;
  endfunction

  function automatic row_t known_row();
    if (added_rows.size() == 0) return fresh_row();
    return added_rows[$urandom_range(added_rows.size() - 1)];
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(logic kind, row_t r);
    if (idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) begin
      if ($urandom_range(99) < ((idle_mode == IDLE_SENDER) ? 80 : 24)) begin
        in_ch.valid <= 1'b0;
        @(negedge clk_i);
        while ($urandom_range(99) < ((idle_mode == IDLE_SENDER) ? 80 : 24))
          @(negedge clk_i);
      end
    end
    in_ch.valid          <= 1'b1;
    in_ch.kind           <= kind;
    in_ch.class_tag      <= r.tag;
    in_ch.area           <= r.area;
    in_ch.perimeter      <= r.perimeter;
    in_ch.major_len      <= r.major_len;
    in_ch.minor_len      <= r.minor_len;
    in_ch.hollow         <= r.hollow;
    in_ch.rectangularity <= r.rectangularity;
    in_ch.solidity       <= r.solidity;
    in_ch.eccentricity   <= r.eccentricity;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
    if (kind) classify_sent++;
    else added_rows.push_back(r);
  endtask

  initial begin
    row_t r;
    row_t zero_row;
    row_t max_row;
    row_t mid_row;
    int   tries;

    zero_row = '0;
    max_row  = '1;
    mid_row  = '{tag: 8'd0, area: 24'h800000, perimeter: 24'h7FFFFF,
                 major_len: 16'h8000, minor_len: 16'h7FFF, hollow: 1'b0,
                 rectangularity: 18'h20000, solidity: 18'h1FFFF, eccentricity: 18'h20000};

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: empty table, field extremes, tag and similarity refusals and ties.
    send_item(1'b1, max_row);
    send_item(1'b0, zero_row);
    send_item(1'b0, max_row);
    send_item(1'b0, max_row);
    r = near_row(max_row);
    r.tag = 8'd7;
    send_item(1'b0, r);
    r = zero_row;
    r.tag = 8'd1;
    send_item(1'b0, r);
    send_item(1'b1, zero_row);
    send_item(1'b1, max_row);
    send_item(1'b1, mid_row);
    r = mid_row;
    r.tag = 8'd2;
    send_item(1'b0, r);
    r = near_row(mid_row);
    r.tag = 8'd3;
    send_item(1'b0, r);
    r = near_row(mid_row);
    r.hollow = 1'b1;
    r.tag = 8'd4;
    send_item(1'b0, r);
    send_item(1'b1, mid_row);
    for (int k = 0; k < 6; k++) send_item(1'b0, fresh_row());
    send_item(1'b1, fresh_row());
    send_item(1'b1, near_row(known_row()));

    // Random part, changing the idling pattern every twenty items.
    for (int k = 0; k < 80; k++) begin
      if (k % 20 == 0) idle_mode = idle_mode_e'((k / 20) % 4);
      case ($urandom_range(9))
        0, 1, 2: send_item(1'b0, fresh_row());
        3:       send_item(1'b0, near_row(known_row()));
        4: begin
          r = fresh_row();
          r.tag = known_row().tag;
          send_item(1'b0, r);
        end
        5, 6, 7: send_item(1'b1, near_row(known_row()));
        default: send_item(1'b1, fresh_row());
      endcase
    end

    // Fill the table to its limit, then probe it while full.
    idle_mode = IDLE_NONE;
    tries = 0;
    while (table_count < MAX_TEMPLATES && tries < 400) begin
      send_item(1'b0, fresh_row());
      tries++;
    end
    idle_mode = IDLE_BOTH;
    send_item(1'b0, fresh_row());
    send_item(1'b0, near_row(known_row()));
    send_item(1'b1, near_row(known_row()));
    send_item(1'b1, fresh_row());
    send_item(1'b1, max_row);
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("Sent %0d items (%0d classify queries), checked %0d results.",
             items_sent, classify_sent, checked);
    $display("Table reached %0d templates; %0d mismatches.", table_count, fail_count);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/rvtc_pkg.sv
rtl/rvtc_in_if.sv
rtl/rvtc_out_if.sv
rtl/rvtc_ram.sv
rtl/rvtc_cmp.sv
rtl/rank_vote_template_classifier.sv
rtl/rvtc_chk.sv
sim/rvtc_checker.sv
sim/tb_rank_vote_template_classifier.sv
